@@ hw/rtl/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Key codes, result codes, configuration defaults and the structs that pass
// between the timeout check, the lock engine and the top level.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Default depth of the entry and stored code buffers.
    localparam int MAX_DIGITS_DEF = 16;

    // Reset code is 1,2,...,8.
    localparam int RST_CODE_LEN = 8;

    localparam int KEY_W      = 4;
    localparam int TICK_W     = 32;
    localparam int TMO_W      = 16;
    localparam int ARM_W      = 2;
    localparam int MINLEN_W   = 5;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CONFIRM   = 4'd10;
    localparam logic [KEY_W-1:0] KEY_ABORT     = 4'd11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TMO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTING_TMO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_ENTERS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN     = 2'd3;

    localparam logic [TMO_W-1:0]    ENTRY_TMO_RST   = 16'd6000;
    localparam logic [TMO_W-1:0]    SETTING_TMO_RST = 16'd10000;
    localparam logic [ARM_W-1:0]    ARM_ENTERS_RST  = 2'd3;
    localparam logic [MINLEN_W-1:0] MIN_LEN_RST     = 5'd4;

    typedef enum logic [3:0] {
        EV_NONE          = 4'd0,
        EV_DIGIT_OK      = 4'd1,
        EV_DIGIT_REJ     = 4'd2,
        EV_UNLOCK        = 4'd3,
        EV_WRONG_CODE    = 4'd4,
        EV_ENTER_COUNTED = 4'd5,
        EV_SETTING_ARMED = 4'd6,
        EV_CODE_SAVED    = 4'd7,
        EV_BAD_LENGTH    = 4'd8,
        EV_CANCEL        = 4'd9
    } event_t;

    typedef enum logic [1:0] {
        TMO_NONE    = 2'd0,
        TMO_ENTRY   = 2'd1,
        TMO_SETTING = 2'd2
    } tmo_kind_t;

    typedef struct packed {
        logic entry_hit;
        logic setting_hit;
    } tmo_hit_t;

    typedef struct packed {
        event_t           ev;
        tmo_kind_t        tkind;
        logic             unlock;
        logic [LEN_W-1:0] len;
        logic             setting;
    } result_t;

endpackage

@@ hw/rtl/kcl_timeout.sv @@
// ----------------------------------------------------------------------------
// kcl_timeout: idle gap check
// Compares the wrapped tick gap since the previous press with the limit of
// the current mode. No check is made while the previous tick is zero.
// ----------------------------------------------------------------------------
module kcl_timeout (
    input  logic [kcl_pkg::TICK_W-1:0] tick_time,
    input  logic [kcl_pkg::TICK_W-1:0] last_tick,
    input  logic                       setting_mode,
    input  logic [kcl_pkg::TMO_W-1:0]  entry_tmo,
    input  logic [kcl_pkg::TMO_W-1:0]  setting_tmo,
    output kcl_pkg::tmo_hit_t          hit
);

    logic [kcl_pkg::TICK_W-1:0] gap;
    logic [kcl_pkg::TMO_W-1:0]  limit;
    logic                       expired;

    // Unsigned subtraction wraps modulo 2^32 on its own.
    assign gap     = tick_time - last_tick;
    assign limit   = setting_mode ? setting_tmo : entry_tmo;
    assign expired = (last_tick != '0) && (gap > kcl_pkg::TICK_W'(limit));

    assign hit.entry_hit   = expired && !setting_mode;
    assign hit.setting_hit = expired && setting_mode;

endmodule

@@ hw/rtl/kcl_engine.sv @@
// ----------------------------------------------------------------------------
// kcl_engine: lock state and key handling
// Holds the entry buffer, the stored code, the enter run counter and the
// setting mode flag, and works out one result for each key press.
// ----------------------------------------------------------------------------
module kcl_engine #(
    parameter int MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic [kcl_pkg::KEY_W-1:0]    key_code,
    input  logic [kcl_pkg::TICK_W-1:0]   tick_time,
    input  logic                         door_open,
    input  logic [kcl_pkg::TMO_W-1:0]    entry_tmo,
    input  logic [kcl_pkg::TMO_W-1:0]    setting_tmo,
    input  logic [kcl_pkg::ARM_W-1:0]    arm_enters,
    input  logic [kcl_pkg::MINLEN_W-1:0] min_len,
    output kcl_pkg::result_t             res
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    // The stored length must hold the reset code length as well.
    localparam int SC_W  = (CNT_W > 4) ? CNT_W : 4;
    localparam int CMP_W = (CNT_W > kcl_pkg::MINLEN_W) ? CNT_W : kcl_pkg::MINLEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

    logic [kcl_pkg::KEY_W-1:0]  entry_digits_reg [MAX_DIGITS];
    logic [kcl_pkg::KEY_W-1:0]  stored_digits_reg [MAX_DIGITS];
    logic [CNT_W-1:0]           entry_count_reg, entry_count_next;
    logic [SC_W-1:0]            stored_count_reg, stored_count_next;
    logic [kcl_pkg::ARM_W-1:0]  enter_run_reg, enter_run_next;
    logic                       setting_mode_reg, setting_mode_next;
    logic [kcl_pkg::TICK_W-1:0] last_tick_reg;

    kcl_pkg::tmo_hit_t            hit;
    logic [CNT_W-1:0]             cnt_a;
    logic [kcl_pkg::ARM_W-1:0]    run_a;
    logic [kcl_pkg::ARM_W-1:0]    run_inc;
    logic                         set_a;
    logic [kcl_pkg::MINLEN_W-1:0] min_eff;
    logic [MAX_DIGITS-1:0]        digit_diff;
    logic                         code_match;
    logic                         digit_wr;
    logic                         code_store;
    logic [IDX_W-1:0]             wr_idx;

    kcl_timeout u_timeout (
        .tick_time    (tick_time),
        .last_tick    (last_tick_reg),
        .setting_mode (setting_mode_reg),
        .entry_tmo    (entry_tmo),
        .setting_tmo  (setting_tmo),
        .hit          (hit)
    );

    // State as it stands after the idle gap check.
    assign cnt_a = (hit.entry_hit || hit.setting_hit) ? '0 : entry_count_reg;
    assign run_a = (hit.entry_hit || hit.setting_hit) ? '0 : enter_run_reg;
    assign set_a = setting_mode_reg && !hit.setting_hit;

    assign run_inc = run_a + kcl_pkg::ARM_W'(1);
    assign min_eff = (min_len == '0) ? kcl_pkg::MINLEN_W'(1) : min_len;
    assign wr_idx  = cnt_a[IDX_W-1:0];

    // Only digits below the entry length take part in the compare.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_diff[i] = (CNT_W'(i) < cnt_a)
                && (entry_digits_reg[i] != stored_digits_reg[i]);
        end
    end
    assign code_match = (SC_W'(cnt_a) == stored_count_reg) && (digit_diff == '0);

    always_comb begin
        entry_count_next  = cnt_a;
        stored_count_next = stored_count_reg;
        enter_run_next    = run_a;
        setting_mode_next = set_a;
        digit_wr          = 1'b0;
        code_store        = 1'b0;
        res.ev            = kcl_pkg::EV_NONE;
        res.unlock        = 1'b0;
        if (key_code == kcl_pkg::KEY_CONFIRM) begin
            enter_run_next = '0;
            if (set_a) begin
                if (CMP_W'(cnt_a) >= CMP_W'(min_eff)) begin
                    code_store        = 1'b1;
                    stored_count_next = SC_W'(cnt_a);
                    setting_mode_next = 1'b0;
                    entry_count_next  = '0;
                    res.ev            = kcl_pkg::EV_CODE_SAVED;
                end else begin
                    res.ev = kcl_pkg::EV_BAD_LENGTH;
                end
            end else if (door_open && cnt_a == '0) begin
                if (run_inc >= arm_enters) begin
                    setting_mode_next = 1'b1;
                    res.ev            = kcl_pkg::EV_SETTING_ARMED;
                end else begin
                    enter_run_next = run_inc;
                    res.ev         = kcl_pkg::EV_ENTER_COUNTED;
                end
            end else if (cnt_a != '0) begin
                entry_count_next = '0;
                if (code_match) begin
                    res.unlock = 1'b1;
                    res.ev     = kcl_pkg::EV_UNLOCK;
                end else begin
                    res.ev = kcl_pkg::EV_WRONG_CODE;
                end
            end
        end else if (key_code == kcl_pkg::KEY_ABORT) begin
            res.ev = kcl_pkg::EV_CANCEL;
        end else if (key_code <= kcl_pkg::KEY_DIGIT_MAX) begin
            if (cnt_a < CNT_MAX) begin
                digit_wr         = 1'b1;
                entry_count_next = cnt_a + CNT_W'(1);
                enter_run_next   = '0;
                res.ev           = kcl_pkg::EV_DIGIT_OK;
            end else begin
                res.ev = kcl_pkg::EV_DIGIT_REJ;
            end
        end
        res.tkind   = hit.setting_hit ? kcl_pkg::TMO_SETTING
                    : (hit.entry_hit ? kcl_pkg::TMO_ENTRY : kcl_pkg::TMO_NONE);
        res.len     = kcl_pkg::LEN_W'(entry_count_next);
        res.setting = setting_mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg  <= '0;
            stored_count_reg <= SC_W'(kcl_pkg::RST_CODE_LEN);
            enter_run_reg    <= '0;
            setting_mode_reg <= 1'b0;
            last_tick_reg    <= '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                stored_digits_reg[i] <= (i < kcl_pkg::RST_CODE_LEN)
                    ? kcl_pkg::KEY_W'(i + 1) : '0;
            end
        end else if (fire) begin
            entry_count_reg  <= entry_count_next;
            stored_count_reg <= stored_count_next;
            enter_run_reg    <= enter_run_next;
            setting_mode_reg <= setting_mode_next;
            last_tick_reg    <= tick_time;
            // Digits past the new length are copied too; they are never compared.
            if (code_store) begin
                stored_digits_reg <= entry_digits_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && digit_wr) begin
            entry_digits_reg[wr_idx] <= key_code;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CNT_MAX)
        else $error("entry count above buffer depth");

    a_unlock_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.unlock |=> entry_count_reg == '0 && !setting_mode_reg)
        else $error("unlock left digits or setting mode behind");

    a_setting_by_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(setting_mode_reg) |-> $past(fire) && $past(key_code) == kcl_pkg::KEY_CONFIRM)
        else $error("setting mode entered without an enter press");

endmodule

@@ hw/rtl/keypad_code_lock.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock: keypad code lock, top level
// Input register, lock engine and result register, with the configuration
// registers.
//
//   Channel   Direction  Fields (lowest bit up)
//   s_        in         key_code[3:0], tick_time[35:4], door_open[36]
//   m_        out        event_res[3:0], timeout_kind[5:4], unlock_command[6],
//                        entry_length[11:7], setting_active[12]
//   cfg_      in         0 entry timeout, 1 setting timeout, 2 arm enters, 3 min length
//
// One transaction per cycle sustained while m_ is not stalled; a result is presented
// on m_ once its transaction has passed the input register, then the result register.
// The key is handled combinationally between the two registers, where the
// 32-bit gap subtract and the parallel code compare set the path.
// Reset is synchronous and restores the default code 12345678 and the defaults
// of all configuration registers; no clearing pass is needed.
// A stall on m_tready holds the result and the waiting input; s_tready drops in
// the same cycle unless the input register is empty, which then takes one more.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
    parameter int MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_code[3:0], tick_time[35:4], door_open[36], zero[39:37]
    input  logic [39:0]                    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_res[3:0], timeout_kind[5:4], unlock_command[6], entry_length[11:7],
    // setting_active[12], zero[15:13]
    output logic [15:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                         in_valid_reg, in_valid_next;
    logic [kcl_pkg::KEY_W-1:0]    key_reg;
    logic [kcl_pkg::TICK_W-1:0]   tick_reg;
    logic                         door_reg;
    logic                         m_valid_reg, m_valid_next;
    kcl_pkg::result_t             res;
    kcl_pkg::result_t             res_reg;
    logic [kcl_pkg::TMO_W-1:0]    entry_tmo_reg;
    logic [kcl_pkg::TMO_W-1:0]    setting_tmo_reg;
    logic [kcl_pkg::ARM_W-1:0]    arm_enters_reg;
    logic [kcl_pkg::MINLEN_W-1:0] min_len_reg;
    logic                         out_free;
    logic                         fire;
    logic                         s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next = s_accept || (in_valid_reg && !fire);
    assign m_valid_next  = fire || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            entry_tmo_reg   <= kcl_pkg::ENTRY_TMO_RST;
            setting_tmo_reg <= kcl_pkg::SETTING_TMO_RST;
            arm_enters_reg  <= kcl_pkg::ARM_ENTERS_RST;
            min_len_reg     <= kcl_pkg::MIN_LEN_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                case (cfg_idx)
                    kcl_pkg::REG_ENTRY_TMO:   entry_tmo_reg   <= cfg_wdata;
                    kcl_pkg::REG_SETTING_TMO: setting_tmo_reg <= cfg_wdata;
                    kcl_pkg::REG_ARM_ENTERS:  arm_enters_reg  <= cfg_wdata[kcl_pkg::ARM_W-1:0];
                    kcl_pkg::REG_MIN_LEN:     min_len_reg     <= cfg_wdata[kcl_pkg::MINLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg  <= s_tdata[3:0];
            tick_reg <= s_tdata[35:4];
            door_reg <= s_tdata[36];
        end
        if (fire) begin
            res_reg <= res;
        end
    end

    kcl_engine #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .key_code    (key_reg),
        .tick_time   (tick_reg),
        .door_open   (door_reg),
        .entry_tmo   (entry_tmo_reg),
        .setting_tmo (setting_tmo_reg),
        .arm_enters  (arm_enters_reg),
        .min_len     (min_len_reg),
        .res         (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.setting, res_reg.len, res_reg.unlock,
                       res_reg.tkind, res_reg.ev};

    a_fire_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("handled transaction did not reach the result register");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_unlock_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.unlock |-> res_reg.ev == kcl_pkg::EV_UNLOCK)
        else $error("unlock command without unlock event");

endmodule
